// File: src/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed message ring package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int unsigned LEN_W    = 10;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BUDGET_W = 7;
  localparam int unsigned PEND_W   = 10;

  localparam logic              OP_APPEND  = 1'b0;
  localparam logic              OP_DRAIN   = 1'b1;
  localparam logic              KIND_STAT  = 1'b0;
  localparam logic              KIND_BYTE  = 1'b1;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;
  localparam int unsigned       OVERHEAD   = 3;

  typedef struct packed {
    logic load;
    logic a_eval;
    logic w_hi;
    logic w_lo;
    logic w_byte;
    logic w_term;
    logic a_stat;
    logic d_rd_hi;
    logic d_rd_lo;
    logic d_len;
    logic d_rd;
    logic d_out;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic refuse;
    logic drop;
    logic arem_zero;
    logic arem_one;
    logic cnt_zero;
    logic active;
    logic ring_empty;
    logic slot_free;
    logic d_end;
    logic d_last;
  } dp_status_t;

endpackage

// File: src/lpmr_ctrl.sv
// ----------------------------------------------------------------------------
// Length-prefixed message ring controller
// Sequences appends and drain ticks and drives the datapath commands.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   operation_i,
  output logic                   in_ready_o,
  input  lpmr_pkg::dp_status_t   stat_i,
  output lpmr_pkg::dp_cmd_t      cmd_o
);
  import lpmr_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_AEVAL = 13'b0000000000010,
    S_WHI   = 13'b0000000000100,
    S_WLO   = 13'b0000000001000,
    S_WBYTE = 13'b0000000010000,
    S_WTERM = 13'b0000000100000,
    S_ASTAT = 13'b0000001000000,
    S_DCHK  = 13'b0000010000000,
    S_DHI   = 13'b0000100000000,
    S_DLO   = 13'b0001000000000,
    S_DLEN  = 13'b0010000000000,
    S_DRD   = 13'b0100000000000,
    S_DOUT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (operation_i == OP_APPEND) ? S_AEVAL : S_DCHK;
        end
      end
      S_AEVAL: begin
        cmd_o.a_eval = 1'b1;
        if (stat_i.first) begin
          state_d = stat_i.refuse ? S_ASTAT : S_WHI;
        end else begin
          state_d = (!stat_i.drop && !stat_i.arem_zero) ? S_WBYTE : S_ASTAT;
        end
      end
      S_WHI: begin
        cmd_o.w_hi = 1'b1;
        state_d    = S_WLO;
      end
      S_WLO: begin
        cmd_o.w_lo = 1'b1;
        state_d    = S_WBYTE;
      end
      S_WBYTE: begin
        cmd_o.w_byte = 1'b1;
        state_d      = stat_i.arem_one ? S_WTERM : S_ASTAT;
      end
      S_WTERM: begin
        cmd_o.w_term = 1'b1;
        state_d      = S_ASTAT;
      end
      S_ASTAT: begin
        if (stat_i.slot_free) begin
          cmd_o.a_stat = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DCHK: begin
        if (stat_i.cnt_zero || (!stat_i.active && stat_i.ring_empty)) begin
          state_d = S_IDLE;
        end else begin
          state_d = stat_i.active ? S_DRD : S_DHI;
        end
      end
      S_DHI: begin
        cmd_o.d_rd_hi = 1'b1;
        state_d       = S_DLO;
      end
      S_DLO: begin
        cmd_o.d_rd_lo = 1'b1;
        state_d       = S_DLEN;
      end
      S_DLEN: begin
        cmd_o.d_len = 1'b1;
        state_d     = S_DRD;
      end
      S_DRD: begin
        cmd_o.d_rd = 1'b1;
        state_d    = S_DOUT;
      end
      S_DOUT: begin
        if (stat_i.slot_free) begin
          cmd_o.d_out = 1'b1;
          if (stat_i.d_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = stat_i.d_end ? S_DHI : S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/lpmr_dpath.sv
// ----------------------------------------------------------------------------
// Length-prefixed message ring datapath
// Byte ring memory, pointers, message counters and the result register.
// ----------------------------------------------------------------------------
module lpmr_dpath #(
  parameter int unsigned RING_DEPTH         = 1024,
  parameter int unsigned MAX_DRAIN_PER_TICK = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            first_of_message_i,
  input  logic [lpmr_pkg::LEN_W-1:0]      message_length_i,
  input  logic [lpmr_pkg::BYTE_W-1:0]     message_byte_i,
  input  logic [lpmr_pkg::BUDGET_W-1:0]   drain_budget_i,
  input  lpmr_pkg::dp_cmd_t               cmd_i,
  output lpmr_pkg::dp_status_t            stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic                            accepted_o,
  output logic [lpmr_pkg::BYTE_W-1:0]     serial_byte_o,
  output logic                            message_end_o,
  output logic [lpmr_pkg::PEND_W-1:0]     pending_after_o,
  output logic                            last_result_o
);
  import lpmr_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = AW + 12;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW:0] pend_of(input logic [AW-1:0] cw, input logic [AW-1:0] rp);
    logic [AW:0] cw_x;
    logic [AW:0] rp_x;
    cw_x = {1'b0, cw};
    rp_x = {1'b0, rp};
    return (cw >= rp) ? (cw_x - rp_x) : (cw_x + (AW+1)'(RING_DEPTH) - rp_x);
  endfunction

  function automatic logic [PEND_W-1:0] pend_out(input logic [AW:0] p);
    logic [AW+PEND_W:0] ext;
    ext = {{PEND_W{1'b0}}, p};
    return ext[PEND_W-1:0];
  endfunction

  logic [BYTE_W-1:0]   mem [RING_DEPTH];
  logic [BYTE_W-1:0]   rd_q;
  logic [BYTE_W-1:0]   hi_q;
  logic                first_q;
  logic [LEN_W-1:0]    len_q;
  logic [BYTE_W-1:0]   byte_q;
  logic [BUDGET_W-1:0] cnt_q;
  logic [AW-1:0]       cwp_q;
  logic [AW-1:0]       wwp_q;
  logic [AW-1:0]       rp_q;
  logic                active_q;
  logic [LEN_W-1:0]    srem_q;
  logic [LEN_W-1:0]    arem_q;
  logic                drop_q;
  logic                acc_q;
  logic                out_valid_q;

  logic [AW:0]         pend_now;
  logic [AW:0]         pend_end;
  logic [AW:0]         pend_mid;
  logic [CW-1:0]       need;
  logic                refuse;
  logic                d_end;
  logic [AW-1:0]       rp_mid;
  logic [AW-1:0]       rp_end;
  logic                slot_free;
  logic [BUDGET_W-1:0] budget_cap;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;

  assign pend_now   = pend_of(cwp_q, rp_q);
  assign need       = CW'(len_q) + CW'(OVERHEAD) + CW'(pend_now);
  assign refuse     = (len_q == '0) || (need > CW'(RING_DEPTH - 1));
  assign d_end      = (srem_q == LEN_W'(1));
  assign rp_mid     = ptr_inc(rp_q);
  assign rp_end     = ptr_inc(rp_mid);
  assign pend_mid   = pend_of(cwp_q, rp_mid);
  assign pend_end   = pend_of(cwp_q, rp_end);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign budget_cap = (drain_budget_i > BUDGET_W'(MAX_DRAIN_PER_TICK)) ?
                      BUDGET_W'(MAX_DRAIN_PER_TICK) : drain_budget_i;

  always_comb begin
    stat_o            = '0;
    stat_o.first      = first_q;
    stat_o.refuse     = refuse;
    stat_o.drop       = drop_q;
    stat_o.arem_zero  = (arem_q == '0);
    stat_o.arem_one   = (arem_q == LEN_W'(1));
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.active     = active_q;
    stat_o.ring_empty = (cwp_q == rp_q);
    stat_o.slot_free  = slot_free;
    stat_o.d_end      = d_end;
    stat_o.d_last     = (cnt_q == BUDGET_W'(1)) || (d_end && (cwp_q == rp_end));
  end

  always_comb begin
    mem_we    = cmd_i.w_hi || cmd_i.w_lo || cmd_i.w_byte || cmd_i.w_term;
    mem_wdata = TERMINATOR;
    if (cmd_i.w_hi) begin
      mem_wdata = BYTE_MASK & BYTE_W'(len_q >> 8);
    end else if (cmd_i.w_lo) begin
      mem_wdata = len_q[BYTE_W-1:0];
    end else if (cmd_i.w_byte) begin
      mem_wdata = byte_q;
    end
    mem_re    = cmd_i.d_rd_hi || cmd_i.d_rd_lo || cmd_i.d_rd;
    mem_raddr = cmd_i.d_rd_lo ? rp_mid : rp_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wwp_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q <= first_of_message_i;
      len_q   <= message_length_i;
      byte_q  <= message_byte_i;
    end
    if (cmd_i.d_rd_lo) begin
      hi_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      cwp_q    <= '0;
      wwp_q    <= '0;
      rp_q     <= '0;
      active_q <= 1'b0;
      srem_q   <= '0;
      arem_q   <= '0;
      drop_q   <= 1'b0;
      acc_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= budget_cap;
      end
      if (cmd_i.a_eval) begin
        acc_q <= 1'b0;
        if (first_q) begin
          wwp_q  <= cwp_q;
          arem_q <= '0;
          drop_q <= refuse;
        end
      end
      if (cmd_i.w_hi) begin
        wwp_q  <= ptr_inc(wwp_q);
        arem_q <= len_q;
      end
      if (cmd_i.w_lo) begin
        wwp_q <= ptr_inc(wwp_q);
      end
      if (cmd_i.w_byte) begin
        wwp_q  <= ptr_inc(wwp_q);
        arem_q <= arem_q - 1'b1;
        acc_q  <= 1'b1;
      end
      if (cmd_i.w_term) begin
        wwp_q <= ptr_inc(wwp_q);
        cwp_q <= ptr_inc(wwp_q);
      end
      if (cmd_i.d_len) begin
        srem_q   <= {hi_q[LEN_W-BYTE_W-1:0], rd_q};
        rp_q     <= rp_end;
        active_q <= 1'b1;
      end
      if (cmd_i.d_out) begin
        cnt_q  <= cnt_q - 1'b1;
        srem_q <= srem_q - 1'b1;
        if (d_end) begin
          rp_q     <= rp_end;
          active_q <= 1'b0;
        end else begin
          rp_q <= rp_mid;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.a_stat || cmd_i.d_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_stat) begin
      kind_o          <= KIND_STAT;
      accepted_o      <= acc_q;
      serial_byte_o   <= '0;
      message_end_o   <= 1'b0;
      pending_after_o <= pend_out(pend_now);
      last_result_o   <= 1'b1;
    end else if (cmd_i.d_out) begin
      kind_o          <= KIND_BYTE;
      accepted_o      <= 1'b0;
      serial_byte_o   <= rd_q;
      message_end_o   <= d_end;
      pending_after_o <= pend_out(d_end ? pend_end : pend_mid);
      last_result_o   <= stat_o.d_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/length_prefixed_message_ring.sv
// ----------------------------------------------------------------------------
// Length-prefixed message ring
// Byte ring that stores whole messages behind a two-byte length and a
// terminator, and drains their bytes in order under a per-tick budget.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Word
//  in       in_valid_i / in_ready_o  append byte or drain tick
//  out      out_valid_o / out_ready_i append status or serial byte
//
// One word is taken at a time; the ring memory has one write and one read
// port. An append writes its byte unless refused or dropped, the two length
// bytes first when it opens a message and the terminator when it closes one.
// A drain tick reads each new length prefix and sends bytes until the budget
// or the ring runs out. Reset clears all pointers and counters at once.
// A stalled output holds the controller in its result state.
module length_prefixed_message_ring #(
  parameter int unsigned RING_DEPTH         = 1024,
  parameter int unsigned MAX_DRAIN_PER_TICK = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic                            first_of_message_i,
  input  logic [lpmr_pkg::LEN_W-1:0]      message_length_i,
  input  logic [lpmr_pkg::BYTE_W-1:0]     message_byte_i,
  input  logic [lpmr_pkg::BUDGET_W-1:0]   drain_budget_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic                            accepted_o,
  output logic [lpmr_pkg::BYTE_W-1:0]     serial_byte_o,
  output logic                            message_end_o,
  output logic [lpmr_pkg::PEND_W-1:0]     pending_after_o,
  output logic                            last_result_o
);
  import lpmr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  lpmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpmr_dpath #(
    .RING_DEPTH         (RING_DEPTH),
    .MAX_DRAIN_PER_TICK (MAX_DRAIN_PER_TICK)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .first_of_message_i (first_of_message_i),
    .message_length_i   (message_length_i),
    .message_byte_i     (message_byte_i),
    .drain_budget_i     (drain_budget_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .accepted_o         (accepted_o),
    .serial_byte_o      (serial_byte_o),
    .message_end_o      (message_end_o),
    .pending_after_o    (pending_after_o),
    .last_result_o      (last_result_o)
  );

endmodule

// File: src/lpmr_checker.sv
// ----------------------------------------------------------------------------
// Length-prefixed message ring checker
// Port-level properties of the ring, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lpmr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            operation_i,
  input logic                            first_of_message_i,
  input logic [lpmr_pkg::LEN_W-1:0]      message_length_i,
  input logic [lpmr_pkg::BYTE_W-1:0]     message_byte_i,
  input logic [lpmr_pkg::BUDGET_W-1:0]   drain_budget_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            kind_o,
  input logic                            accepted_o,
  input logic [lpmr_pkg::BYTE_W-1:0]     serial_byte_o,
  input logic                            message_end_o,
  input logic [lpmr_pkg::PEND_W-1:0]     pending_after_o,
  input logic                            last_result_o
);
  import lpmr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(serial_byte_o)
      && $stable(kind_o) && $stable(pending_after_o) && $stable(last_result_o))
    else $error("Stalled output word changed.");

  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_STAT) |-> last_result_o && !message_end_o
      && (serial_byte_o == '0))
    else $error("Append status word is malformed.");

  a_byte_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BYTE) |-> !accepted_o)
    else $error("Serial byte word carries an accept flag.");

  a_append_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_APPEND) |=> !in_ready_o)
    else $error("Input taken again right after an append.");

  a_idle_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_DRAIN) && (drain_budget_i == '0)
      |=> !in_ready_o ##1 in_ready_o)
    else $error("Empty drain tick did not return to idle.");

endmodule

bind length_prefixed_message_ring lpmr_checker u_lpmr_checker (.*);
